@@ hdl/bal_pkg.sv @@
`timescale 1ns / 1ps

package bal_pkg;

    localparam int CMD_W      = 3;
    localparam int IDX_W      = 7;
    localparam int VAL_W      = 32;
    localparam int CAP_W      = 7;
    localparam int OUT_DATA_W = 32;
    localparam int COUNT_W    = 7;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 1;

    localparam int DEFAULT_DEPTH      = 64;
    localparam int DEFAULT_DATA_WIDTH = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_REMOVE = 3'd4
    } cmd_t;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_EXEC      = 8'b0000_0010,
        ST_GET       = 8'b0000_0100,
        ST_INS       = 8'b0000_1000,
        ST_INS_LAST  = 8'b0001_0000,
        ST_REM       = 8'b0010_0000,
        ST_REM_SHIFT = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic                  ok;
        logic [OUT_DATA_W-1:0] data;
        logic [COUNT_W-1:0]    count;
        logic                  full;
        logic                  empty;
    } result_t;

endpackage

@@ hdl/bounded_array_list_unit.sv @@
`timescale 1ns / 1ps

// Bounded array list of up to DEPTH words held in one synchronous RAM. One request is
// worked at a time. Set, append, insert at the end and refused requests finish in the
// execute state and get adds a RAM read state; insert and remove at index i take longer,
// because the later words move one entry per cycle through the RAM's single write port.
// A finished result waits in the output register while the next request is accepted. The
// RAM needs no clearing pass after reset, since only entries below count are ever read.
module bounded_array_list_unit #(
    parameter int DEPTH      = bal_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = bal_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: index[6:0], value[38:7].
    input  logic [bal_pkg::S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: cmd[2:0].
    input  logic [bal_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: data[31:0], count[38:32], full_res[39], empty_res[40].
    output logic [bal_pkg::M_TDATA_W-1:0]   m_tdata,
    // Fields from bit 0: ok[0].
    output logic [bal_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            cfg_we,
    input  logic [bal_pkg::CAP_W-1:0]       cfg_wdata
);

    import bal_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
    logic                  res_valid, res_ready;
    result_t               res;

    bal_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_cmd     (cmd_t'(s_tuser)),
        .s_index   (s_tdata[IDX_W-1:0]),
        .s_value   (s_tdata[IDX_W+VAL_W-1:IDX_W]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    bal_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bal_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hdl/bal_ram.sv @@
`timescale 1ns / 1ps

module bal_ram #(
    parameter int DEPTH      = bal_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = bal_pkg::DEFAULT_DATA_WIDTH,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/bal_ctrl.sv @@
`timescale 1ns / 1ps

module bal_ctrl #(
    parameter int DEPTH      = bal_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = bal_pkg::DEFAULT_DATA_WIDTH,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bal_pkg::cmd_t               s_cmd,
    input  logic [bal_pkg::IDX_W-1:0]   s_index,
    input  logic [bal_pkg::VAL_W-1:0]   s_value,
    input  logic                        cfg_we,
    input  logic [bal_pkg::CAP_W-1:0]   cfg_wdata,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [DATA_WIDTH-1:0]       ram_wdata,
    output logic                        ram_re,
    output logic [AW-1:0]               ram_raddr,
    input  logic [DATA_WIDTH-1:0]       ram_rdata,
    output logic                        res_valid,
    input  logic                        res_ready,
    output bal_pkg::result_t            res
);

    import bal_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic                  ok_reg, ok_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [CAP_W-1:0]      cap_cfg_reg;

    logic [CMPW-1:0] idx_ext, fill_ext, cfg_ext, depth_ext, cap_eff;
    logic            idx_lt_fill, idx_le_fill, room;
    logic [AW-1:0]   idx_a, fill_a;

    assign s_ready   = (state_reg == ST_IDLE);
    assign idx_ext   = CMPW'(idx_reg);
    assign fill_ext  = CMPW'(fill_reg);
    assign cfg_ext   = CMPW'(cap_cfg_reg);
    assign depth_ext = CMPW'(DEPTH);
    assign idx_a     = AW'(idx_reg);
    assign fill_a    = AW'(fill_reg);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            cap_eff = CMPW'(1);
        end
        else if (cfg_ext > depth_ext)
        begin
            cap_eff = depth_ext;
        end
        else
        begin
            cap_eff = cfg_ext;
        end
    end

    assign idx_lt_fill = (idx_ext < fill_ext);
    assign idx_le_fill = (idx_ext <= fill_ext);
    assign room        = (fill_ext < cap_eff);

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        fill_next  = fill_reg;
        ok_next    = ok_reg;
        data_next  = data_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg;
        res_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ok_next    = 1'b0;
                data_next  = '0;
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_GET:
                    begin
                        if (idx_lt_fill)
                        begin
                            ok_next    = 1'b1;
                            ram_re     = 1'b1;
                            ram_raddr  = idx_a;
                            state_next = ST_GET;
                        end
                    end
                    CMD_SET:
                    begin
                        if (idx_lt_fill)
                        begin
                            ok_next   = 1'b1;
                            data_next = val_reg;
                            ram_we    = 1'b1;
                            ram_waddr = idx_a;
                            ram_wdata = val_reg;
                        end
                    end
                    CMD_APPEND:
                    begin
                        if (room)
                        begin
                            ok_next   = 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = fill_a;
                            ram_wdata = val_reg;
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (room && idx_le_fill)
                        begin
                            ok_next = 1'b1;
                            if (idx_ext == fill_ext)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = fill_a;
                                ram_wdata = val_reg;
                                fill_next = fill_reg + CW'(1);
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = fill_a - AW'(1);
                                ptr_next   = fill_a;
                                state_next = ST_INS;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (idx_lt_fill)
                        begin
                            ok_next    = 1'b1;
                            ram_re     = 1'b1;
                            ram_raddr  = idx_a;
                            state_next = ST_REM;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_GET:
            begin
                data_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                if ((ptr_reg - AW'(1)) == idx_a)
                begin
                    state_next = ST_INS_LAST;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg - AW'(2);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end
            ST_INS_LAST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_a;
                ram_wdata  = val_reg;
                fill_next  = fill_reg + CW'(1);
                state_next = ST_DONE;
            end
            ST_REM:
            begin
                data_next = ram_rdata;
                fill_next = fill_reg - CW'(1);
                if ((idx_ext + CMPW'(1)) == fill_ext)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_a + AW'(1);
                    ptr_next   = idx_a;
                    state_next = ST_REM_SHIFT;
                end
            end
            ST_REM_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                if ((CMPW'(ptr_reg) + CMPW'(1)) == fill_ext)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + AW'(2);
                    ptr_next  = ptr_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.ok    = ok_reg;
    assign res.data  = OUT_DATA_W'(data_reg);
    assign res.count = COUNT_W'(fill_reg);
    assign res.full  = (fill_ext >= cap_eff);
    assign res.empty = (fill_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            cap_cfg_reg <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_we)
            begin
                cap_cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        ok_reg   <= ok_next;
        data_reg <= data_next;
        if (s_valid && s_ready)
        begin
            cmd_reg <= s_cmd;
            idx_reg <= s_index;
            val_reg <= DATA_WIDTH'(s_value);
        end
    end

endmodule

@@ hdl/bal_out.sv @@
`timescale 1ns / 1ps

module bal_out (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_valid,
    output logic                            res_ready,
    input  bal_pkg::result_t                res,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bal_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [bal_pkg::M_TUSER_W-1:0]   m_tuser
);

    import bal_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tuser   = res_reg.ok;
    assign m_tdata   = M_TDATA_W'({res_reg.empty, res_reg.full, res_reg.count, res_reg.data});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

@@ hdl/bal_checker.sv @@
`timescale 1ns / 1ps

module bal_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bal_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [bal_pkg::M_TUSER_W-1:0]   m_tuser
);

    import bal_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[40] == (m_tdata[38:32] == 7'd0)))
        else $error("empty flag disagrees with count");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[31:0] == 32'd0))
        else $error("refused request returned nonzero data");

    a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> !m_tdata[39])
        else $error("list reported both empty and full");

endmodule

bind bounded_array_list_unit bal_checker u_bal_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import bal_pkg::*;

    localparam int LIST_DEPTH  = DEFAULT_DEPTH;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES  = 8;
    localparam int DIR_ROWS    = 25;

    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        bit               has_exp;
        result_t          res;
    } dir_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CAP_W-1:0]      cfg_wdata = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    logic [VAL_W-1:0]      list_words [LIST_DEPTH];
    int                    list_count = 0;
    logic [CAP_W-1:0]      cap_reg    = CAP_RESET;
    result_t               pending_results [$];
    int                    mismatches   = 0;
    int                    stall_cycles = 0;
    bit                    quiet        = 1'b0;
    dir_row_t              dir_rows [DIR_ROWS];

    bounded_array_list_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int eff_capacity();
        int c;
        c = int'(cap_reg);
        if (c < 1)
            c = 1;
        if (c > LIST_DEPTH)
            c = LIST_DEPTH;
        return c;
    endfunction

    function automatic result_t list_apply(logic [CMD_W-1:0] cmd, int idx,
                                           logic [VAL_W-1:0] val);
        result_t r;
        int      cap;
        int      i;
        r   = '0;
        cap = eff_capacity();
        case (cmd)
            CMD_GET:
            begin
                if (idx < list_count)
                begin
                    r.ok   = 1'b1;
                    r.data = list_words[idx];
                end
            end
            CMD_SET:
            begin
                if (idx < list_count)
                begin
                    list_words[idx] = val;
                    r.ok   = 1'b1;
                    r.data = val;
                end
            end
            CMD_APPEND:
            begin
                if (list_count < cap)
                begin
                    list_words[list_count] = val;
                    list_count++;
                    r.ok = 1'b1;
                end
            end
            CMD_INSERT:
            begin
                if (list_count < cap && idx <= list_count)
                begin
                    for (i = list_count; i > idx; i--)
                        list_words[i] = list_words[i-1];
                    list_words[idx] = val;
                    list_count++;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (idx < list_count)
                begin
                    r.data = list_words[idx];
                    list_count--;
                    for (i = idx; i < list_count; i++)
                        list_words[i] = list_words[i+1];
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = list_count[COUNT_W-1:0];
        r.full  = (list_count >= cap);
        r.empty = (list_count == 0);
        return r;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] val, input bit has_exp,
                                input result_t exp_res);
        result_t r;
        while (!quiet && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, idx};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = list_apply(cmd, int'(idx), val);
        pending_results.push_back(has_exp ? exp_res : r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_reg    = v;
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser[0], m_tdata[31:0], m_tdata[38:32], m_tdata[39], m_tdata[40]};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: ok=%0b data=%h count=%0d",
                             got.ok, got.data, got.count,
                             " full=%0b empty=%0b", got.full, got.empty);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected ok=%0b data=%h count=%0d",
                                 want.ok, want.data, want.count,
                                 " full=%0b empty=%0b,", want.full, want.empty,
                                 " got ok=%0b data=%h count=%0d",
                                 got.ok, got.data, got.count,
                                 " full=%0b empty=%0b", got.full, got.empty);
                end
            end
        end
        m_tready <= quiet || ($urandom_range(99) >= 33);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [CAP_W-1:0] phase_cap [NUM_PHASES];
        int               phase_grow [NUM_PHASES];
        int               phase_shrink [NUM_PHASES];
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic [CAP_W-1:0] cap;
        int               r;
        int               i;
        int               ph;
        int               n;

        dir_rows = '{
            '{CMD_GET,    7'd0,  32'h0,        1'b1, '{1'b0, 32'h0,        7'd0, 1'b0, 1'b1}},
            '{CMD_REMOVE, 7'd0,  32'h0,        1'b1, '{1'b0, 32'h0,        7'd0, 1'b0, 1'b1}},
            '{CMD_SET,    7'd0,  32'hFFFFFFFF, 1'b1, '{1'b0, 32'h0,        7'd0, 1'b0, 1'b1}},
            '{CMD_INSERT, 7'd1,  32'h5,        1'b1, '{1'b0, 32'h0,        7'd0, 1'b0, 1'b1}},
            '{CMD_APPEND, 7'd64, 32'hFFFFFFFF, 1'b1, '{1'b1, 32'h0,        7'd1, 1'b0, 1'b0}},
            '{CMD_GET,    7'd0,  32'h0,        1'b1, '{1'b1, 32'hFFFFFFFF, 7'd1, 1'b0, 1'b0}},
            '{CMD_INSERT, 7'd0,  32'h0,        1'b1, '{1'b1, 32'h0,        7'd2, 1'b0, 1'b0}},
            '{CMD_INSERT, 7'd2,  32'hA5A5A5A5, 1'b1, '{1'b1, 32'h0,        7'd3, 1'b0, 1'b0}},
            '{CMD_INSERT, 7'd1,  32'h12345678, 1'b0, '0},
            '{CMD_SET,    7'd3,  32'h5A5A5A5A, 1'b1, '{1'b1, 32'h5A5A5A5A, 7'd4, 1'b0, 1'b0}},
            '{CMD_GET,    7'd64, 32'h0,        1'b1, '{1'b0, 32'h0,        7'd4, 1'b0, 1'b0}},
            '{CMD_RSVD_5, 7'd0,  32'h1,        1'b1, '{1'b0, 32'h0,        7'd4, 1'b0, 1'b0}},
            '{CMD_RSVD_6, 7'd1,  32'hFFFFFFFF, 1'b1, '{1'b0, 32'h0,        7'd4, 1'b0, 1'b0}},
            '{CMD_RSVD_7, 7'd2,  32'h80000000, 1'b1, '{1'b0, 32'h0,        7'd4, 1'b0, 1'b0}},
            '{CMD_INSERT, 7'd5,  32'h3,        1'b1, '{1'b0, 32'h0,        7'd4, 1'b0, 1'b0}},
            '{CMD_GET,    7'd1,  32'h0,        1'b0, '0},
            '{CMD_REMOVE, 7'd1,  32'h0,        1'b0, '0},
            '{CMD_REMOVE, 7'd2,  32'h0,        1'b0, '0},
            '{CMD_REMOVE, 7'd2,  32'h0,        1'b1, '{1'b0, 32'h0,        7'd2, 1'b0, 1'b0}},
            '{CMD_GET,    7'd0,  32'h0,        1'b0, '0},
            '{CMD_GET,    7'd1,  32'h0,        1'b0, '0},
            '{CMD_REMOVE, 7'd0,  32'h0,        1'b0, '0},
            '{CMD_REMOVE, 7'd0,  32'h0,        1'b0, '0},
            '{CMD_APPEND, 7'd0,  32'h7FFFFFFF, 1'b0, '0},
            '{CMD_SET,    7'd0,  32'h80000001, 1'b1, '{1'b1, 32'h80000001, 7'd1, 1'b0, 1'b0}}
        };
        phase_cap    = '{7'd64, 7'd127, 7'd3, 7'd1, 7'd0, 7'd40, 7'd2, 7'd0};
        phase_grow   = '{65, 40, 15, 40, 40, 60, 30, 45};
        phase_shrink = '{15, 35, 60, 30, 30, 20, 40, 30};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_request(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].val,
                         dir_rows[i].has_exp, dir_rows[i].res);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            cap = (ph == NUM_PHASES - 1) ? CAP_W'($urandom_range(64, 1)) : phase_cap[ph];
            write_capacity(cap);
            quiet = (ph == 1);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (r < phase_grow[ph])
                    cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
                else if (r < phase_grow[ph] + phase_shrink[ph])
                    cmd = CMD_REMOVE;
                else if (r < 97)
                    cmd = $urandom_range(1) ? CMD_GET : CMD_SET;
                else
                    cmd = CMD_W'($urandom_range(CMD_RSVD_7, CMD_RSVD_5));
                if ($urandom_range(99) < 80)
                begin
                    if (cmd == CMD_INSERT)
                        idx = IDX_W'($urandom_range(list_count));
                    else
                        idx = (list_count == 0) ? '0 : IDX_W'($urandom_range(list_count - 1));
                end
                else
                    idx = IDX_W'($urandom_range(64));
                r = $urandom_range(19);
                if (r == 0)
                    val = '0;
                else if (r == 1)
                    val = '1;
                else
                    val = $urandom;
                send_request(cmd, idx, val, 1'b0, '0);
            end
            wait_drained();
        end
        quiet = 1'b0;

        repeat (80) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bal_pkg.sv
hdl/bal_ram.sv
hdl/bal_ctrl.sv
hdl/bal_out.sv
hdl/bounded_array_list_unit.sv
hdl/bal_checker.sv
tb/tb_top.sv
